FILE: hw/rtl/seek_steering_vector_assert.svh
// ----------------------------------------------------------------------------
// Seek steering vector assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEEK_STEERING_VECTOR_ASSERT_SVH
`define SEEK_STEERING_VECTOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define SSV_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ssv_pkg.sv
// ----------------------------------------------------------------------------
// Seek steering vector package
// Widths, types and the arctangent table of the block; its checker shares the types.
// ----------------------------------------------------------------------------
package ssv_pkg;

    localparam int unsigned DIFF_W       = 25;
    localparam int unsigned SQ_W         = 48;
    localparam int unsigned SUM_W        = 49;
    localparam int unsigned RAD_W        = 64;
    localparam int unsigned ROOT_W       = 32;
    localparam int unsigned REM_W        = 34;
    localparam int unsigned MAG_W        = 40;
    localparam int unsigned NUM_W        = 48;
    localparam int unsigned QUO_W        = 16;
    localparam int unsigned CORD_W       = 36;
    localparam int unsigned ANGLE_W      = 32;
    localparam int unsigned ATAN_ENTRIES = 24;

    typedef logic signed [23:0] t_pos;
    typedef logic signed [15:0] t_head;
    typedef logic        [15:0] t_speed;
    typedef logic signed [16:0] t_vel;
    typedef logic [ANGLE_W-1:0] t_angle;
    typedef t_angle t_atan_tab [ATAN_ENTRIES];

    localparam t_pos OFF_MAP_X = -24'sd12800;
    localparam t_speed SPEED_RESET = 16'd256;
    localparam t_angle ANGLE_PI = 32'h8000_0000;
    localparam t_angle ANGLE_HALF_LSB = 32'h0000_8000;

    localparam t_atan_tab ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic  off;
        logic  zero;
        logic  neg_x;
        logic  neg_y;
        t_head heading;
    } t_side;

endpackage

FILE: hw/rtl/seek_steering_vector.sv
// ----------------------------------------------------------------------------
// Seek steering vector
// Velocity toward a target at configured speed, plus the new heading.
// ----------------------------------------------------------------------------
// Takes one query per cycle while o_stall is low and returns one result per
// query, in order. The pipeline holds a 32-step square root followed by a
// 16-step divider per velocity component; the heading CORDIC runs beside the
// square root. A stall on the result side freezes the whole pipeline, which
// then stalls the query side in the same cycle.
module seek_steering_vector #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  ssv_pkg::t_speed i_cfg_data,
    input  logic           i_valid,
    output logic           o_stall,
    input  ssv_pkg::t_pos  i_src_x,
    input  ssv_pkg::t_pos  i_src_y,
    input  ssv_pkg::t_pos  i_dst_x,
    input  ssv_pkg::t_pos  i_dst_y,
    input  ssv_pkg::t_head i_heading_in,
    output logic           o_valid,
    input  logic           i_stall,
    output ssv_pkg::t_vel  o_vel_x,
    output ssv_pkg::t_vel  o_vel_y,
    output ssv_pkg::t_head o_heading_out,
    output logic           o_target_off_map
);
    import ssv_pkg::*;

    localparam int NC = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int NSQ = ROOT_W;
    localparam int NDV = QUO_W;

    logic en;
    logic r_out_valid;
    t_speed r_max_speed;

    assign en          = !(r_out_valid && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= SPEED_RESET;
        end else if (i_cfg_valid) begin
            r_max_speed <= i_cfg_data;
        end
    end

    // stage A: differences
    logic                     r_a_valid;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy, n_a_dx, n_a_dy;
    logic                     r_a_off, n_a_off;
    t_head                    r_a_heading;

    always_comb begin
        n_a_dx  = DIFF_W'(i_dst_x) - DIFF_W'(i_src_x);
        n_a_dy  = DIFF_W'(i_dst_y) - DIFF_W'(i_src_y);
        n_a_off = (i_dst_x < OFF_MAP_X);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx      <= n_a_dx;
            r_a_dy      <= n_a_dy;
            r_a_off     <= n_a_off;
            r_a_heading <= i_heading_in;
        end
    end

    // stage B: squares, scaled magnitudes, CORDIC start
    logic                     r_b_valid;
    logic [SQ_W-1:0]          r_b_sqx, r_b_sqy, n_b_sqx, n_b_sqy;
    logic [MAG_W-1:0]         r_b_mx, r_b_my, n_b_mx, n_b_my;
    logic signed [CORD_W-1:0] r_b_x, r_b_y, n_b_x, n_b_y;
    t_angle                   r_b_z, n_b_z;
    t_side                    r_b_side, n_b_side;
    logic [23:0]              abs_x, abs_y;
    logic signed [CORD_W-1:0] y_scaled;

    always_comb begin
        abs_x    = r_a_dx[DIFF_W-1] ? 24'(-r_a_dx) : r_a_dx[23:0];
        abs_y    = r_a_dy[DIFF_W-1] ? 24'(-r_a_dy) : r_a_dy[23:0];
        n_b_sqx  = abs_x * abs_x;
        n_b_sqy  = abs_y * abs_y;
        n_b_mx   = MAG_W'(abs_x) * MAG_W'(r_max_speed);
        n_b_my   = MAG_W'(abs_y) * MAG_W'(r_max_speed);
        y_scaled = CORD_W'(r_a_dy) <<< 8;
        n_b_x    = $signed({4'b0, abs_x, 8'b0});
        n_b_y    = r_a_dx[DIFF_W-1] ? -y_scaled : y_scaled;
        n_b_z    = r_a_dx[DIFF_W-1] ? ANGLE_PI : '0;
        n_b_side = '{off: r_a_off, zero: 1'b0, neg_x: r_a_dx[DIFF_W-1],
                     neg_y: r_a_dy[DIFF_W-1], heading: r_a_heading};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sqx  <= n_b_sqx;
            r_b_sqy  <= n_b_sqy;
            r_b_mx   <= n_b_mx;
            r_b_my   <= n_b_my;
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_z    <= n_b_z;
            r_b_side <= n_b_side;
        end
    end

    // square root stages with the CORDIC alongside; element 0 is stage C
    logic                     r_s_valid [0:NSQ];
    logic [SUM_W-1:0]         r_s_sum   [0:NSQ];
    logic [REM_W-1:0]         r_s_rem   [0:NSQ];
    logic [ROOT_W-1:0]        r_s_root  [0:NSQ];
    logic [MAG_W-1:0]         r_s_mx    [0:NSQ];
    logic [MAG_W-1:0]         r_s_my    [0:NSQ];
    logic signed [CORD_W-1:0] r_s_x     [0:NSQ];
    logic signed [CORD_W-1:0] r_s_y     [0:NSQ];
    t_angle                   r_s_z     [0:NSQ];
    t_side                    r_s_side  [0:NSQ];
    logic [SUM_W-1:0]         n_c_sum;
    t_side                    n_c_side;

    always_comb begin
        n_c_sum       = SUM_W'(r_b_sqx) + SUM_W'(r_b_sqy);
        n_c_side      = r_b_side;
        n_c_side.zero = (n_c_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_sum[0]  <= n_c_sum;
            r_s_rem[0]  <= '0;
            r_s_root[0] <= '0;
            r_s_mx[0]   <= r_b_mx;
            r_s_my[0]   <= r_b_my;
            r_s_x[0]    <= r_b_x;
            r_s_y[0]    <= r_b_y;
            r_s_z[0]    <= r_b_z;
            r_s_side[0] <= n_c_side;
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam int HI = RAD_W - 1 - 2 * k;
        logic [RAD_W-1:0]         rad;
        logic [REM_W+1:0]         cur_rem, trial;
        logic [REM_W-1:0]         n_rem;
        logic [ROOT_W-1:0]        n_root;
        logic signed [CORD_W-1:0] xs, ys, n_x, n_y;
        t_angle                   n_z;

        always_comb begin
            rad     = {1'b0, r_s_sum[k], 14'b0};
            cur_rem = {r_s_rem[k], rad[HI -: 2]};
            trial   = {2'b0, r_s_root[k], 2'b01};
            if (cur_rem >= trial) begin
                n_rem  = REM_W'(cur_rem - trial);
                n_root = {r_s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(cur_rem);
                n_root = {r_s_root[k][ROOT_W-2:0], 1'b0};
            end
            xs = r_s_x[k] >>> k;
            ys = r_s_y[k] >>> k;
            if (k >= NC) begin
                n_x = r_s_x[k];
                n_y = r_s_y[k];
                n_z = r_s_z[k];
            end else if (!r_s_y[k][CORD_W-1]) begin
                n_x = r_s_x[k] + ys;
                n_y = r_s_y[k] - xs;
                n_z = r_s_z[k] + ATAN_TAB[k % ATAN_ENTRIES];
            end else begin
                n_x = r_s_x[k] - ys;
                n_y = r_s_y[k] + xs;
                n_z = r_s_z[k] - ATAN_TAB[k % ATAN_ENTRIES];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_sum[k+1]  <= r_s_sum[k];
                r_s_rem[k+1]  <= n_rem;
                r_s_root[k+1] <= n_root;
                r_s_mx[k+1]   <= r_s_mx[k];
                r_s_my[k+1]   <= r_s_my[k];
                r_s_x[k+1]    <= n_x;
                r_s_y[k+1]    <= n_y;
                r_s_z[k+1]    <= n_z;
                r_s_side[k+1] <= r_s_side[k];
            end
        end
    end

    // divider stages; element 0 forms the rounded numerators
    logic              r_d_valid [0:NDV];
    logic [ROOT_W-1:0] r_d_len   [0:NDV];
    logic [ROOT_W-1:0] r_d_remx  [0:NDV];
    logic [ROOT_W-1:0] r_d_remy  [0:NDV];
    logic [QUO_W-1:0]  r_d_lowx  [0:NDV];
    logic [QUO_W-1:0]  r_d_lowy  [0:NDV];
    logic [QUO_W-1:0]  r_d_qx    [0:NDV];
    logic [QUO_W-1:0]  r_d_qy    [0:NDV];
    t_angle            r_d_z     [0:NDV];
    t_side             r_d_side  [0:NDV];
    logic [NUM_W-1:0]  n_num_x, n_num_y;

    always_comb begin
        n_num_x = NUM_W'({r_s_mx[NSQ], 7'b0}) + NUM_W'(r_s_root[NSQ] >> 1);
        n_num_y = NUM_W'({r_s_my[NSQ], 7'b0}) + NUM_W'(r_s_root[NSQ] >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_len[0]  <= r_s_root[NSQ];
            r_d_remx[0] <= n_num_x[NUM_W-1 -: ROOT_W];
            r_d_remy[0] <= n_num_y[NUM_W-1 -: ROOT_W];
            r_d_lowx[0] <= n_num_x[QUO_W-1:0];
            r_d_lowy[0] <= n_num_y[QUO_W-1:0];
            r_d_qx[0]   <= '0;
            r_d_qy[0]   <= '0;
            r_d_z[0]    <= r_s_z[NSQ];
            r_d_side[0] <= r_s_side[NSQ];
        end
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        logic [ROOT_W:0]   tx, ty, len_ext;
        logic [ROOT_W-1:0] n_remx, n_remy;
        logic [QUO_W-1:0]  n_qx, n_qy;

        always_comb begin
            len_ext = {1'b0, r_d_len[k]};
            tx      = {r_d_remx[k], r_d_lowx[k][QUO_W-1-k]};
            ty      = {r_d_remy[k], r_d_lowy[k][QUO_W-1-k]};
            if (tx >= len_ext) begin
                n_remx = ROOT_W'(tx - len_ext);
                n_qx   = {r_d_qx[k][QUO_W-2:0], 1'b1};
            end else begin
                n_remx = ROOT_W'(tx);
                n_qx   = {r_d_qx[k][QUO_W-2:0], 1'b0};
            end
            if (ty >= len_ext) begin
                n_remy = ROOT_W'(ty - len_ext);
                n_qy   = {r_d_qy[k][QUO_W-2:0], 1'b1};
            end else begin
                n_remy = ROOT_W'(ty);
                n_qy   = {r_d_qy[k][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_len[k+1]  <= r_d_len[k];
                r_d_remx[k+1] <= n_remx;
                r_d_remy[k+1] <= n_remy;
                r_d_lowx[k+1] <= r_d_lowx[k];
                r_d_lowy[k+1] <= r_d_lowy[k];
                r_d_qx[k+1]   <= n_qx;
                r_d_qy[k+1]   <= n_qy;
                r_d_z[k+1]    <= r_d_z[k];
                r_d_side[k+1] <= r_d_side[k];
            end
        end
    end

    // output register
    t_vel   r_vel_x, r_vel_y, n_vel_x, n_vel_y;
    t_head  r_heading, n_heading;
    logic   r_off;
    logic   still;
    t_side  fin;
    t_angle z_round;

    always_comb begin
        fin     = r_d_side[NDV];
        still   = fin.off || fin.zero || (r_d_qx[NDV] == '0 && r_d_qy[NDV] == '0);
        z_round = r_d_z[NDV] + ANGLE_HALF_LSB;
        if (still) begin
            n_vel_x   = '0;
            n_vel_y   = '0;
            n_heading = fin.heading;
        end else begin
            n_vel_x   = fin.neg_x ? -$signed({1'b0, r_d_qx[NDV]}) : $signed({1'b0, r_d_qx[NDV]});
            n_vel_y   = fin.neg_y ? -$signed({1'b0, r_d_qy[NDV]}) : $signed({1'b0, r_d_qy[NDV]});
            n_heading = $signed(z_round[ANGLE_W-1 -: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vel_x   <= n_vel_x;
            r_vel_y   <= n_vel_y;
            r_heading <= n_heading;
            r_off     <= fin.off;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_d_valid[NDV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
            r_d_valid[0] <= 1'b0;
        end else if (en) begin
            r_s_valid[0] <= r_b_valid;
            r_d_valid[0] <= r_s_valid[NSQ];
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_s_valid[k+1] <= r_s_valid[k];
            end
        end
    end

    for (genvar k = 0; k < NDV; k++) begin : g_dvv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_d_valid[k+1] <= r_d_valid[k];
            end
        end
    end

    assign o_vel_x          = r_vel_x;
    assign o_vel_y          = r_vel_y;
    assign o_heading_out    = r_heading;
    assign o_target_off_map = r_off;

endmodule

FILE: hw/rtl/ssv_chk.sv
// ----------------------------------------------------------------------------
// Seek steering vector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "seek_steering_vector_assert.svh"

module ssv_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input ssv_pkg::t_vel  o_vel_x,
    input ssv_pkg::t_vel  o_vel_y,
    input ssv_pkg::t_head o_heading_out,
    input logic           o_target_off_map
);
    import ssv_pkg::*;

    `SSV_ASSERT_NEXT(a_hold_beat, o_valid && i_stall,
        o_valid && $stable(o_vel_x) && $stable(o_vel_y) && $stable(o_heading_out),
        "stalled beat changed")
    `SSV_ASSERT_NOW(a_off_map_still, o_valid && o_target_off_map,
        o_vel_x == '0 && o_vel_y == '0, "off-map target moved")
    `SSV_ASSERT_NOW(a_vel_range, o_valid,
        o_vel_x != 17'h10000 && o_vel_y != 17'h10000, "velocity out of range")
    `SSV_ASSERT_RST(a_reset_empty, !i_rst_n, !o_valid, "result after reset")

endmodule

bind seek_steering_vector ssv_chk u_ssv_chk (.*);
